[hw/rtl/cilp_pkg.sv]
`default_nettype none

package cilp_pkg;

    localparam logic [1:0] BASE_DEC = 2'd0;
    localparam logic [1:0] BASE_OCT = 2'd1;
    localparam logic [1:0] BASE_HEX = 2'd2;

    localparam logic [3:0] ERR_OK         = 4'd0;
    localparam logic [3:0] ERR_EMPTY      = 4'd1;
    localparam logic [3:0] ERR_BAD_CHAR   = 4'd2;
    localparam logic [3:0] ERR_BAD_SUFFIX = 4'd3;
    localparam logic [3:0] ERR_SFX_SMALL  = 4'd4;
    localparam logic [3:0] ERR_MALFORMED  = 4'd5;
    localparam logic [3:0] ERR_EXPONENT   = 4'd6;
    localparam logic [3:0] ERR_FLOAT      = 4'd7;
    localparam logic [3:0] ERR_LONGLONG   = 4'd8;

    localparam logic [2:0] TYPE_NONE  = 3'd0;
    localparam logic [2:0] TYPE_INT   = 3'd1;
    localparam logic [2:0] TYPE_UINT  = 3'd2;
    localparam logic [2:0] TYPE_LONG  = 3'd3;
    localparam logic [2:0] TYPE_ULONG = 3'd5;

    // suffix kinds share the type code numbering where they overlap
    localparam logic [3:0] SFX_NONE = 4'd0;
    localparam logic [3:0] SFX_U    = 4'd2;
    localparam logic [3:0] SFX_L    = 4'd3;
    localparam logic [3:0] SFX_LL   = 4'd4;
    localparam logic [3:0] SFX_LU   = 4'd5;
    localparam logic [3:0] SFX_LLU  = 4'd6;
    localparam logic [3:0] SFX_BAD  = 4'd9;

    localparam logic [31:0] LIM_INT  = 32'd32767;
    localparam logic [31:0] LIM_UINT = 32'd65535;
    localparam logic [31:0] LIM_LONG = 32'd2147483647;
    localparam logic [4:0]  NOT_A_DIGIT = 5'd17;

    typedef struct packed {
        logic x_misplaced;
        logic dot_after_e;
        logic bad_digit;
        logic space;
        logic lead_zero;
    } lit_flags_t;

    typedef struct packed {
        logic [1:0]      char_position;
        logic [1:0]      number_base;
        logic [31:0]     accumulated_value;
        logic [1:0]      dot_count;
        logic [1:0]      exp_count;
        logic [1:0]      hex_mark_count;
        lit_flags_t      status_flags;
        logic [2:0]      suffix_length;
        logic [2:0][7:0] suffix_chars;
    } lit_state_t;

    typedef struct packed {
        logic [3:0]  error_code;
        logic [2:0]  type_code;
        logic [31:0] literal_value;
    } lit_result_t;

    localparam lit_state_t LIT_CLEAR = '0;

    function automatic logic [1:0] sat3(input logic [1:0] v);
        sat3 = (v == 2'd3) ? 2'd3 : v + 2'd1;
    endfunction

    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        digit_of = NOT_A_DIGIT;
        if (c >= "0" && c <= "9") begin
            d = c - "0";
            digit_of = d[4:0];
        end else if (c >= "a" && c <= "f") begin
            d = c - "a" + 8'd10;
            digit_of = d[4:0];
        end else if (c >= "A" && c <= "F") begin
            d = c - "A" + 8'd10;
            digit_of = d[4:0];
        end
    endfunction

    function automatic logic [4:0] radix_of(input logic [1:0] base);
        case (base)
            BASE_HEX: radix_of = 5'd16;
            BASE_OCT: radix_of = 5'd8;
            default:  radix_of = 5'd10;
        endcase
    endfunction

endpackage

`default_nettype wire

[hw/rtl/cilp_step.sv]
`default_nettype none

// Per-character update of the literal state.
module cilp_step (
    input  wire cilp_pkg::lit_state_t state_in,
    input  wire logic [7:0]           char_code,
    input  wire logic                 first_char,
    output cilp_pkg::lit_state_t      state_out
);

    cilp_pkg::lit_state_t st;
    logic [1:0]  pos;
    logic        is_x;
    logic        is_sfx;
    logic [4:0]  radix;
    logic [4:0]  digit;
    logic [31:0] scaled;

    always_comb begin
        st     = first_char ? cilp_pkg::LIT_CLEAR : state_in;
        pos    = st.char_position;
        is_x   = char_code inside {"x", "X"};
        is_sfx = char_code inside {"U", "u", "L", "l"};
        radix  = 5'd10;
        digit  = cilp_pkg::NOT_A_DIGIT;
        scaled = 32'd0;

        if (char_code == " ") st.status_flags.space = 1'b1;
        if (pos == 2'd0 && char_code == "0") st.status_flags.lead_zero = 1'b1;

        if (pos != 2'd0 && is_sfx) begin
            if (st.suffix_length < 3'd3) st.suffix_chars[st.suffix_length[1:0]] = char_code;
            if (st.suffix_length < 3'd4) st.suffix_length = st.suffix_length + 3'd1;
        end else begin
            // anything after suffix letters turns them into bad digits
            if (st.suffix_length != 3'd0) begin
                st.status_flags.bad_digit = 1'b1;
                st.suffix_length = 3'd0;
            end
            if (is_x) begin
                st.hex_mark_count = cilp_pkg::sat3(st.hex_mark_count);
                if (pos == 2'd1 && st.status_flags.lead_zero) begin
                    st.number_base = cilp_pkg::BASE_HEX;
                end else begin
                    st.status_flags.x_misplaced = 1'b1;
                end
            end else begin
                if (char_code == ".") begin
                    st.dot_count = cilp_pkg::sat3(st.dot_count);
                    if (st.exp_count != 2'd0) st.status_flags.dot_after_e = 1'b1;
                end
                if (char_code inside {"e", "E"}) st.exp_count = cilp_pkg::sat3(st.exp_count);
                if (pos == 2'd1 && st.status_flags.lead_zero) st.number_base = cilp_pkg::BASE_OCT;
                radix = cilp_pkg::radix_of(st.number_base);
                digit = cilp_pkg::digit_of(char_code);
                case (st.number_base)
                    cilp_pkg::BASE_HEX: scaled = {st.accumulated_value[27:0], 4'b0};
                    cilp_pkg::BASE_OCT: scaled = {st.accumulated_value[28:0], 3'b0};
                    default: scaled = {st.accumulated_value[28:0], 3'b0}
                                    + {st.accumulated_value[30:0], 1'b0};
                endcase
                if (digit >= radix) begin
                    st.status_flags.bad_digit = 1'b1;
                end else begin
                    st.accumulated_value = scaled + {27'd0, digit};
                end
            end
        end

        // a suffix letter in second place still marks the literal octal
        if (pos == 2'd1 && !is_x && st.status_flags.lead_zero
                && st.number_base == cilp_pkg::BASE_DEC) begin
            st.number_base = cilp_pkg::BASE_OCT;
        end

        if (st.char_position < 2'd2) st.char_position = st.char_position + 2'd1;

        state_out = st;
    end

endmodule

`default_nettype wire

[hw/rtl/cilp_finish.sv]
`default_nettype none

// Error, type and value for a literal whose last character was just applied.
module cilp_finish (
    input  wire cilp_pkg::lit_state_t state,
    input  wire logic [7:0]           char_code,
    output cilp_pkg::lit_result_t     result
);

    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] ch_l;
    logic [7:0] ch_u;
    logic [3:0] sfx;
    logic [3:0] req;
    logic [3:0] fin;

    always_comb begin
        a = state.suffix_chars[0];
        b = state.suffix_chars[1];
        c = state.suffix_chars[2];
        ch_l = (a >= "A" && a <= "Z") ? "L" : "l";
        ch_u = (a >= "A" && a <= "Z") ? "U" : "u";

        case (state.suffix_length)
            3'd0: sfx = cilp_pkg::SFX_NONE;
            3'd1: begin
                if (a == ch_u)      sfx = cilp_pkg::SFX_U;
                else if (a == ch_l) sfx = cilp_pkg::SFX_L;
                else                sfx = cilp_pkg::SFX_BAD;
            end
            3'd2: begin
                if (a == ch_l && b == ch_u)      sfx = cilp_pkg::SFX_LU;
                else if (a == ch_l && b == ch_l) sfx = cilp_pkg::SFX_LL;
                else                             sfx = cilp_pkg::SFX_BAD;
            end
            3'd3: begin
                if (a == ch_l && b == ch_l && c == ch_u) sfx = cilp_pkg::SFX_LLU;
                else                                     sfx = cilp_pkg::SFX_BAD;
            end
            default: sfx = cilp_pkg::SFX_BAD;
        endcase

        if (state.accumulated_value > cilp_pkg::LIM_LONG)      req = {1'b0, cilp_pkg::TYPE_ULONG};
        else if (state.accumulated_value > cilp_pkg::LIM_UINT) req = {1'b0, cilp_pkg::TYPE_LONG};
        else if (state.accumulated_value > cilp_pkg::LIM_INT)  req = {1'b0, cilp_pkg::TYPE_UINT};
        else                                                   req = {1'b0, cilp_pkg::TYPE_INT};

        fin = (sfx != cilp_pkg::SFX_NONE) ? sfx : req;

        result.type_code     = cilp_pkg::TYPE_NONE;
        result.literal_value = 32'd0;

        if (state.status_flags.space) begin
            result.error_code = cilp_pkg::ERR_BAD_CHAR;
        end else if (state.hex_mark_count == 2'd0 && (state.dot_count > 2'd1
                     || state.exp_count > 2'd1)) begin
            result.error_code = cilp_pkg::ERR_MALFORMED;
        end else if (state.hex_mark_count == 2'd0 && state.exp_count != 2'd0
                     && (char_code inside {"e", "E"} || state.status_flags.dot_after_e)) begin
            result.error_code = cilp_pkg::ERR_EXPONENT;
        end else if (state.hex_mark_count == 2'd0 && (state.dot_count != 2'd0
                     || state.exp_count != 2'd0)) begin
            result.error_code = cilp_pkg::ERR_FLOAT;
        end else if (state.hex_mark_count != 2'd0 && (state.dot_count != 2'd0
                     || state.status_flags.x_misplaced)) begin
            result.error_code = cilp_pkg::ERR_MALFORMED;
        end else if (state.status_flags.bad_digit) begin
            result.error_code = cilp_pkg::ERR_BAD_CHAR;
        end else if (sfx == cilp_pkg::SFX_BAD) begin
            result.error_code = cilp_pkg::ERR_BAD_SUFFIX;
        end else if (sfx != cilp_pkg::SFX_NONE && req > sfx) begin
            result.error_code = cilp_pkg::ERR_SFX_SMALL;
        end else if (fin == cilp_pkg::SFX_LL || fin == cilp_pkg::SFX_LLU) begin
            result.error_code = cilp_pkg::ERR_LONGLONG;
        end else begin
            result.error_code    = cilp_pkg::ERR_OK;
            result.type_code     = fin[2:0];
            result.literal_value = state.accumulated_value;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/c_integer_literal_parser.sv]
`default_nettype none

// Channel | Dir | Handshake          | Payload
// s_      | in  | s_valid / s_ready  | char_code[8], first_char, last_char, empty_literal
// m_      | out | m_valid / m_ready  | error_code[4], type_code[3], literal_value[32]
//
// One character per cycle while s_ready is high; the literal state updates in the cycle
// the request is taken, and the result sits in the output register in the cycle after
// the last character. The shift-add scale of the running value sets the critical path.
// Synchronous active-low reset clears the literal state and the output valid.
// s_ready drops only while a held result is not taken by m_ready.
module c_integer_literal_parser (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_char_code,
    input  wire logic        s_first_char,
    input  wire logic        s_last_char,
    input  wire logic        s_empty_literal,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_error_code,
    output logic [2:0]       m_type_code,
    output logic [31:0]      m_literal_value
);

    cilp_pkg::lit_state_t  state_reg, state_next;
    cilp_pkg::lit_state_t  step_state;
    cilp_pkg::lit_result_t fin_result;
    cilp_pkg::lit_result_t result_reg, result_next;
    logic                  valid_reg, valid_next;
    logic                  accept;
    logic                  done;

    cilp_step u_step (
        .state_in   (state_reg),
        .char_code  (s_char_code),
        .first_char (s_first_char),
        .state_out  (step_state)
    );

    cilp_finish u_finish (
        .state     (step_state),
        .char_code (s_char_code),
        .result    (fin_result)
    );

    assign s_ready = !valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign done    = s_empty_literal || s_last_char;

    always_comb begin
        state_next  = state_reg;
        result_next = result_reg;
        valid_next  = valid_reg && !m_ready;
        if (accept) begin
            state_next = done ? cilp_pkg::LIT_CLEAR : step_state;
            if (done) begin
                valid_next = 1'b1;
                if (s_empty_literal) begin
                    result_next.error_code    = cilp_pkg::ERR_EMPTY;
                    result_next.type_code     = cilp_pkg::TYPE_NONE;
                    result_next.literal_value = 32'd0;
                end else begin
                    result_next = fin_result;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cilp_pkg::LIT_CLEAR;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

    assign m_valid         = valid_reg;
    assign m_error_code    = result_reg.error_code;
    assign m_type_code     = result_reg.type_code;
    assign m_literal_value = result_reg.literal_value;

endmodule

`default_nettype wire

[tb/c_integer_literal_parser_tb.sv]
`timescale 1ns / 1ps

module c_integer_literal_parser_tb;

    typedef logic [7:0] char_q_t[$];

    // Tracks the literal being lexed and queues the result each closing request should produce.
    class literal_tracker;
        bit [1:0]    at_pos;
        bit [1:0]    num_base;
        bit [31:0]   value_acc;
        bit [1:0]    n_dot;
        bit [1:0]    n_exp;
        bit [1:0]    n_x;
        bit          lead_zero;
        bit          saw_space;
        bit          bad_digit;
        bit          dot_after_exp;
        bit          x_misplaced;
        bit [2:0]    sfx_len;
        bit [7:0]    sfx_chr [3];
        cilp_pkg::lit_result_t awaited[$];
        int          n_chars;
        int          n_results;
        int          n_failures;
        bit [8:0]    codes_seen;

        function new();
            clear();
            n_chars = 0;
            n_results = 0;
            n_failures = 0;
            codes_seen = '0;
        endfunction

        function void clear();
            at_pos = 2'd0;
            num_base = cilp_pkg::BASE_DEC;
            value_acc = 32'd0;
            n_dot = 2'd0;
            n_exp = 2'd0;
            n_x = 2'd0;
            lead_zero = 1'b0;
            saw_space = 1'b0;
            bad_digit = 1'b0;
            dot_after_exp = 1'b0;
            x_misplaced = 1'b0;
            sfx_len = 3'd0;
            foreach (sfx_chr[i]) sfx_chr[i] = 8'd0;
        endfunction

        function bit [1:0] bump(bit [1:0] v);
            return (v == 2'd3) ? v : v + 2'd1;
        endfunction

        // case of the first suffix letter sets the case the rest must match
        function bit [3:0] suffix_kind();
            bit       upper;
            bit [7:0] ch_l;
            bit [7:0] ch_u;
            upper = (sfx_chr[0] >= "A" && sfx_chr[0] <= "Z");
            ch_l = upper ? "L" : "l";
            ch_u = upper ? "U" : "u";
            case (sfx_len)
                3'd0: return cilp_pkg::SFX_NONE;
                3'd1: begin
                    if (sfx_chr[0] == ch_u) return cilp_pkg::SFX_U;
                    if (sfx_chr[0] == ch_l) return cilp_pkg::SFX_L;
                end
                3'd2: begin
                    if (sfx_chr[0] == ch_l && sfx_chr[1] == ch_u) return cilp_pkg::SFX_LU;
                    if (sfx_chr[0] == ch_l && sfx_chr[1] == ch_l) return cilp_pkg::SFX_LL;
                end
                3'd3: begin
                    if (sfx_chr[0] == ch_l && sfx_chr[1] == ch_l && sfx_chr[2] == ch_u)
                        return cilp_pkg::SFX_LLU;
                end
                default: ;
            endcase
            return cilp_pkg::SFX_BAD;
        endfunction

        function cilp_pkg::lit_result_t verdict(bit [7:0] c);
            cilp_pkg::lit_result_t r;
            bit [3:0]    sfx;
            int          need;
            r = '0;
            sfx = suffix_kind();
            if (saw_space) begin
                r.error_code = cilp_pkg::ERR_BAD_CHAR;
            end else if (n_x == 0 && (n_dot > 1 || n_exp > 1)) begin
                r.error_code = cilp_pkg::ERR_MALFORMED;
            end else if (n_x == 0 && (n_dot != 0 || n_exp != 0)) begin
                if (n_exp != 0 && (c == "e" || c == "E" || dot_after_exp))
                    r.error_code = cilp_pkg::ERR_EXPONENT;
                else
                    r.error_code = cilp_pkg::ERR_FLOAT;
            end else if (n_x != 0 && (n_dot != 0 || x_misplaced)) begin
                r.error_code = cilp_pkg::ERR_MALFORMED;
            end else if (bad_digit) begin
                r.error_code = cilp_pkg::ERR_BAD_CHAR;
            end else if (sfx == cilp_pkg::SFX_BAD) begin
                r.error_code = cilp_pkg::ERR_BAD_SUFFIX;
            end else begin
                if (value_acc > cilp_pkg::LIM_LONG)      need = cilp_pkg::TYPE_ULONG;
                else if (value_acc > cilp_pkg::LIM_UINT) need = cilp_pkg::TYPE_LONG;
                else if (value_acc > cilp_pkg::LIM_INT)  need = cilp_pkg::TYPE_UINT;
                else                                     need = cilp_pkg::TYPE_INT;
                if (sfx != cilp_pkg::SFX_NONE && need > sfx) begin
                    r.error_code = cilp_pkg::ERR_SFX_SMALL;
                end else begin
                    if (sfx != cilp_pkg::SFX_NONE) need = sfx;
                    if (need == cilp_pkg::SFX_LL || need == cilp_pkg::SFX_LLU) begin
                        r.error_code = cilp_pkg::ERR_LONGLONG;
                    end else begin
                        r.type_code = need[2:0];
                        r.literal_value = value_acc;
                    end
                end
            end
            return r;
        endfunction

        function void take_char(bit [7:0] c, bit first, bit last, bit empty);
            cilp_pkg::lit_result_t r;
            bit          is_x;
            bit          is_sfx;
            bit [1:0]    here;
            int          rad;
            int          dig;
            n_chars++;
            if (empty) begin
                clear();
                r = '0;
                r.error_code = cilp_pkg::ERR_EMPTY;
                awaited.push_back(r);
                return;
            end
            if (first) clear();
            here = at_pos;
            is_x = (c == "x" || c == "X");
            is_sfx = (c == "U" || c == "u" || c == "L" || c == "l");
            if (c == " ") saw_space = 1'b1;
            if (here == 2'd0 && c == "0") lead_zero = 1'b1;

            if (here != 2'd0 && is_sfx) begin
                if (sfx_len < 3) sfx_chr[sfx_len] = c;
                if (sfx_len < 4) sfx_len++;
            end else begin
                // anything after a suffix letter flags a bad digit, then is handled as usual
                if (sfx_len != 0) begin
                    bad_digit = 1'b1;
                    sfx_len = 3'd0;
                end
                if (is_x) begin
                    n_x = bump(n_x);
                    if (here == 2'd1 && lead_zero) num_base = cilp_pkg::BASE_HEX;
                    else x_misplaced = 1'b1;
                end else begin
                    if (c == ".") begin
                        n_dot = bump(n_dot);
                        if (n_exp != 0) dot_after_exp = 1'b1;
                    end
                    if (c == "e" || c == "E") n_exp = bump(n_exp);
                    if (here == 2'd1 && lead_zero) num_base = cilp_pkg::BASE_OCT;
                    rad = (num_base == cilp_pkg::BASE_HEX) ? 16 :
                          (num_base == cilp_pkg::BASE_OCT) ? 8 : 10;
                    if (c >= "0" && c <= "9")      dig = c - "0";
                    else if (c >= "a" && c <= "f") dig = c - "a" + 10;
                    else if (c >= "A" && c <= "F") dig = c - "A" + 10;
                    else                           dig = 99;
                    if (dig >= rad) bad_digit = 1'b1;
                    else value_acc = value_acc * rad + dig;
                end
            end
            // a suffix letter in second place still makes a leading zero octal
            if (here == 2'd1 && !is_x && lead_zero && num_base == cilp_pkg::BASE_DEC)
                num_base = cilp_pkg::BASE_OCT;
            if (at_pos < 2) at_pos++;

            if (last) begin
                awaited.push_back(verdict(c));
                clear();
            end
        endfunction

        function void check_result(logic [3:0] err, logic [2:0] typ, logic [31:0] val);
            cilp_pkg::lit_result_t want;
            n_results++;
            if (err <= cilp_pkg::ERR_LONGLONG) codes_seen[err] = 1'b1;
            if (awaited.size() == 0) begin
                $display("%0t: result with nothing awaited: error_code %0d type_code %0d value %0h",
                         $time, err, typ, val);
                n_failures++;
                return;
            end
            want = awaited.pop_front();
            if (want.error_code !== err) begin
                $display("%0t: error_code expected %0d actual %0d", $time, want.error_code, err);
                n_failures++;
            end
            if (want.type_code !== typ) begin
                $display("%0t: type_code expected %0d actual %0d", $time, want.type_code, typ);
                n_failures++;
            end
            if (want.literal_value !== val) begin
                $display("%0t: literal_value expected %0h actual %0h",
                         $time, want.literal_value, val);
                n_failures++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_char_code = 8'd0;
    logic        s_first_char = 1'b0;
    logic        s_last_char = 1'b0;
    logic        s_empty_literal = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_error_code;
    logic [2:0]  m_type_code;
    logic [31:0] m_literal_value;

    literal_tracker tracker;
    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;
    bit             hold_request = 1'b0;

    string suffix_menu [17] = '{"u", "U", "l", "L", "lu", "LU", "ll", "LL", "llu", "LLU",
                                "Lu", "ul", "lL", "LLL", "llul", "uu", "lU"};
    string noise_set = " 0xXuUlL.eE9g";
    string bad_digits = "89gGz#_";
    int    idle_plan [4] = '{0, 61, 0, 21};
    int    stall_plan [4] = '{0, 0, 61, 21};

    c_integer_literal_parser u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_code    (s_char_code),
        .s_first_char   (s_first_char),
        .s_last_char    (s_last_char),
        .s_empty_literal(s_empty_literal),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_error_code   (m_error_code),
        .m_type_code    (m_type_code),
        .m_literal_value(m_literal_value)
    );

    always #5 aclk = ~aclk;

    task automatic send_req(input logic [7:0] c, input logic f, input logic l, input logic e);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_valid = 1'b0;
            s_char_code = $urandom_range(255);
        end
        @(negedge aclk);
        s_valid = 1'b1;
        s_char_code = c;
        s_first_char = f;
        s_last_char = l;
        s_empty_literal = e;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.take_char(c, f, l, e);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_req(s[i], i == 0, i == s.len() - 1, 1'b0);
    endtask

    task automatic send_random_literal();
        char_q_t     lit;
        logic [31:0] v;
        logic [7:0]  c;
        int          kind;
        int          rad;
        int          d;
        int          n;
        bit          upper;
        string       sfx;
        kind = $urandom_range(99);
        if (kind >= 85) begin
            // noise: arbitrary bytes and marks, may leave a literal open
            n = $urandom_range(1, 5);
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(1)) c = $urandom_range(255);
                else c = noise_set[$urandom_range(noise_set.len() - 1)];
                send_req(c, $urandom_range(3) == 0,
                         (k == n - 1) ? ($urandom_range(4) != 0) : ($urandom_range(7) == 0),
                         $urandom_range(9) == 0);
            end
            return;
        end

        case ($urandom_range(6))
            0:       v = $urandom_range(9);
            1:       v = $urandom;
            2:       v = cilp_pkg::LIM_INT + $urandom_range(1);
            3:       v = cilp_pkg::LIM_UINT + $urandom_range(1);
            4:       v = cilp_pkg::LIM_LONG + $urandom_range(1);
            5:       v = 32'hFFFF_FFFF;
            default: v = $urandom_range(99999);
        endcase
        d = $urandom_range(2);
        rad = (d == 0) ? 10 : (d == 1) ? 8 : 16;
        upper = $urandom_range(1);
        do begin
            d = v % rad;
            lit.push_front(d < 10 ? 8'("0" + d) : 8'((upper ? "A" : "a") + d - 10));
            v = v / rad;
        end while (v != 0);
        // extra leading digits can push the value past 32 bits
        if (rad == 10 && $urandom_range(7) == 0)
            repeat ($urandom_range(1, 3)) lit.push_front(8'("1" + $urandom_range(8)));
        if (rad == 8) lit.push_front("0");
        if (rad == 16) begin
            if ($urandom_range(15) == 0) lit.delete();
            lit.push_front(upper ? "X" : "x");
            lit.push_front("0");
        end

        if (kind < 60) begin
            if ($urandom_range(11) == 0)
                lit[$urandom_range(lit.size() - 1)] =
                    bad_digits[$urandom_range(bad_digits.len() - 1)];
        end else if (kind < 75) begin
            repeat ($urandom_range(1, 2))
                lit.insert($urandom_range(lit.size()),
                           $urandom_range(1) ? "." : ($urandom_range(1) ? "e" : "E"));
        end else begin
            lit.insert($urandom_range(lit.size()), $urandom_range(1) ? "x" : "X");
        end

        if ($urandom_range(9) < 5) begin
            sfx = suffix_menu[$urandom_range(16)];
            for (int i = 0; i < sfx.len(); i++) lit.push_back(sfx[i]);
        end

        for (int i = 0; i < lit.size(); i++)
            send_req(lit[i], i == 0 && $urandom_range(15) != 0, i == lit.size() - 1, 1'b0);
    endtask

    // result side: random stalls, plus one long hold-off when asked
    initial begin
        int hold_left;
        hold_left = 0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_left = 80;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready = 1'b0;
            end else begin
                m_ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_result(m_error_code, m_type_code, m_literal_value);
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int target;
        tracker = new();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_req(8'hFF, 1'b1, 1'b1, 1'b1);
        send_req(8'h00, 1'b0, 1'b0, 1'b1);
        send_req(8'h00, 1'b1, 1'b1, 1'b0);
        send_req(8'hFF, 1'b1, 1'b1, 1'b0);
        send_text("0x");
        send_text("1 ");
        send_text("1u2");
        send_text("7LLLL");
        send_text("1LL");
        send_text("08");
        send_text("1e");
        send_text("1.5");
        send_text("0xffffffff");

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_plan[ph];
            recv_stall_pct = stall_plan[ph];
            target = tracker.n_chars + 105;
            while (tracker.n_chars < target) send_random_literal();
        end

        // back-pressure: a held result stalls the requests that keep coming
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 1'b1;
        repeat (20) send_text("5");

        @(negedge aclk);
        s_valid = 1'b0;
        while (tracker.awaited.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (tracker.awaited.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, tracker.awaited.size());
            tracker.n_failures++;
        end

        $display("Lexed %0d characters under four idle/stall mixes and a long hold-off;",
                 tracker.n_chars);
        $display("checked %0d results, error codes hit (bit per code): %b",
                 tracker.n_results, tracker.codes_seen);
        if (tracker.n_failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
